// ===== rtl/core/sac_pkg.sv =====
package sac_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int MAX_LAGS        = 64;
	localparam int LAG_W           = 6;
	localparam int LAG_MAX_W       = 7;
	localparam int MEAN_FRAC       = 8;
	localparam int MEAN_W          = SAMPLE_BITS + MEAN_FRAC;
	localparam int DEV_W           = MEAN_W + 1;
	localparam int PROD_W          = 2 * DEV_W;
	localparam int ACC_W           = 64;
	localparam int CORR_W          = 16;
	localparam int FRAC_STEPS      = 16;

	localparam logic CFG_LAG_MIN = 1'b0;
	localparam logic CFG_LAG_MAX = 1'b1;

	typedef enum logic [4:0] {
		ST_LOAD = 5'b00001,
		ST_MEAN = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

endpackage

// ===== rtl/core/sample_autocorrelation_unit.sv =====
// Sample autocorrelation unit.
// Input stream: s_tdata carries one signed sample, s_tlast marks the final
// sample of a series. Samples load one per cycle into an on-chip store;
// samples past MAX_SAMPLES are dropped, but a tlast still closes the series.
// After tlast the unit computes the mean with a bit-serial divider (one
// load step and 38 quotient steps), then the lag-zero sum of products and
// one sum per emitted lag below the sample count (none for zero variance) by
// a multiply-accumulate walk over the store, one product per cycle from a
// dual-read memory, then a serial divide to Q1.15 that ends early when the
// result saturates. Output stream: m_tdata = {correlation, lag}, m_tuser =
// undefined (zero variance), m_tlast = final lag of the run. One result
// register sits on the output; the walk pauses while it is full and the
// receiver holds m_tready low. s_tready is low while a series is computed.
// Reset (arst_n low) empties the series and sets lag_min 0, lag_max 64;
// the sample store itself needs no clearing. cfg_we writes lag_min
// (index 0) or lag_max (index 1) from cfg_data.
module sample_autocorrelation_unit #(
	parameter int MAX_SAMPLES = sac_pkg::MAX_SAMPLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [sac_pkg::LAG_MAX_W-1:0]     cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sac_pkg::SAMPLE_BITS-1:0]   s_tdata,   // [15:0] sample
	input  logic                              s_tlast,   // is_last
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [23:0]                       m_tdata,   // [5:0] lag, [21:6] correlation
	output logic                              m_tuser,   // undefined
	output logic                              m_tlast    // last_of_run
);
	import sac_pkg::*;

	localparam int AW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = SAMPLE_BITS + CNT_W;
	localparam int NUM_W  = SUM_W + MEAN_FRAC + 1;
	localparam int STEP_N = (NUM_W > FRAC_STEPS) ? NUM_W : FRAC_STEPS;
	localparam int STEP_W = $clog2(STEP_N + 1);

	state_t state_q;

	logic [LAG_W-1:0]      lag_min_q;
	logic [LAG_MAX_W-1:0]  lag_max_q;
	logic [LAG_MAX_W-1:0]  hi_q;
	logic [LAG_MAX_W-1:0]  lag_q;
	logic [CNT_W-1:0]      cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [MEAN_W-1:0] mean_q;

	logic [NUM_W-1:0]      num_q;
	logic [CNT_W-1:0]      rem_q;
	logic                  mneg_q;
	logic [STEP_W-1:0]     step_q;

	logic [CNT_W-1:0]      j_q;
	logic [CNT_W-1:0]      end_q;
	logic                  vphase_q;
	logic [ACC_W-1:0]      acc_q;
	logic [ACC_W-1:0]      var_q;
	logic                  undef_q;
	logic                  zero_q;

	logic [ACC_W-1:0]      mag_q;
	logic                  neg_q;
	logic                  sat_q;
	logic [ACC_W-1:0]      drem_q;
	logic [FRAC_STEPS-1:0] frac_q;

	logic                  v_s1, v_s2, v_s3;
	logic signed [SAMPLE_BITS-1:0] rd_a_s1, rd_b_s1;
	logic signed [DEV_W-1:0] dev_a_s2, dev_b_s2;
	logic signed [PROD_W-1:0] prod_s3;

	logic                  m_valid_q;
	logic [23:0]           m_data_q;
	logic                  m_user_q;
	logic                  m_last_q;

	logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

	// Input side and memory control
	logic                  in_acc;
	logic                  store_en;
	logic                  issue;
	logic [CNT_W-1:0]      j_plus_lag;
	logic                  sum_done;
	logic                  out_free;
	logic [LAG_MAX_W-1:0]  hi_in;
	logic [CNT_W:0]        mean_trial;
	logic [ACC_W:0]        frac_trial;
	logic [SUM_W-1:0]      sum_mag;
	logic [CORR_W:0]       rounded;
	logic [CORR_W-1:0]     corr_val;
	logic [LAG_MAX_W-1:0]  next_lag;
	logic                  next_zero;
	logic [ACC_W-1:0]      acc_neg;

	assign in_acc     = s_tvalid && s_tready;
	assign store_en   = in_acc && (cnt_q < CNT_W'(MAX_SAMPLES));
	assign issue      = (state_q == ST_SUM) && (j_q < end_q);
	assign j_plus_lag = j_q + CNT_W'(lag_q);
	assign sum_done   = (state_q == ST_SUM) && !issue && !v_s1 && !v_s2 && !v_s3;
	assign out_free   = !m_valid_q || m_tready;
	assign hi_in      = (lag_max_q > LAG_MAX_W'(MAX_LAGS)) ? LAG_MAX_W'(MAX_LAGS) : lag_max_q;
	assign mean_trial = {rem_q, num_q[NUM_W-1]};
	assign frac_trial = {drem_q, 1'b0};
	assign sum_mag    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign rounded    = ({1'b0, frac_q} + (CORR_W+1)'(1)) >> 1;
	assign next_lag   = lag_q + LAG_MAX_W'(1);
	assign next_zero  = undef_q || (CNT_W'(next_lag) >= cnt_q);
	assign acc_neg    = -acc_q;

	always_comb begin
		if (zero_q) begin
			corr_val = '0;
		end else if (sat_q) begin
			corr_val = neg_q ? {1'b1, {(CORR_W-1){1'b0}}} : {1'b0, {(CORR_W-1){1'b1}}};
		end else if (neg_q) begin
			corr_val = CORR_W'(-rounded);
		end else if (rounded[CORR_W-1]) begin
			corr_val = {1'b0, {(CORR_W-1){1'b1}}};
		end else begin
			corr_val = rounded[CORR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[cnt_q[AW-1:0]] <= s_tdata;
		end
		rd_a_s1 <= mem[j_q[AW-1:0]];
		rd_b_s1 <= mem[j_plus_lag[AW-1:0]];
	end

	// Deviation and product stages
	always_ff @(posedge clk) begin
		dev_a_s2 <= DEV_W'($signed({rd_a_s1, {MEAN_FRAC{1'b0}}})) - DEV_W'(mean_q);
		dev_b_s2 <= DEV_W'($signed({rd_b_s1, {MEAN_FRAC{1'b0}}})) - DEV_W'(mean_q);
		prod_s3  <= dev_a_s2 * dev_b_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_min_q <= '0;
			lag_max_q <= LAG_MAX_W'(MAX_LAGS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LAG_MIN: lag_min_q <= cfg_data[LAG_W-1:0];
				CFG_LAG_MAX: lag_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			if (issue) begin
				j_q <= j_q + CNT_W'(1);
			end
			if (v_s3) begin
				acc_q <= acc_q + ACC_W'(prod_s3);
			end
		end
		unique case (state_q)
			ST_LOAD: ;
			ST_MEAN: begin
				if (step_q == '0) begin
					// load the numerator once the final sample is counted
					mneg_q <= sum_q[SUM_W-1];
					num_q  <= NUM_W'({sum_mag, {MEAN_FRAC{1'b0}}}) + NUM_W'(cnt_q >> 1);
					rem_q  <= '0;
					hi_q   <= hi_in;
				end else begin
					if (mean_trial >= {1'b0, cnt_q}) begin
						rem_q <= CNT_W'(mean_trial - {1'b0, cnt_q});
						num_q <= {num_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= mean_trial[CNT_W-1:0];
						num_q <= {num_q[NUM_W-2:0], 1'b0};
					end
					if (step_q == STEP_W'(NUM_W)) begin
						mean_q   <= mneg_q ? MEAN_W'(-{1'b0, num_q[NUM_W-2:0], (mean_trial >= {1'b0, cnt_q})})
						                   : MEAN_W'({num_q[NUM_W-2:0], (mean_trial >= {1'b0, cnt_q})});
						vphase_q <= 1'b1;
						lag_q    <= '0;
						j_q      <= '0;
						end_q    <= cnt_q;
						acc_q    <= '0;
					end
				end
			end
			ST_SUM: begin
				if (sum_done) begin
					if (vphase_q) begin
						vphase_q <= 1'b0;
						var_q    <= acc_q;
						undef_q  <= (acc_q == '0);
						lag_q    <= LAG_MAX_W'(lag_min_q);
						zero_q   <= (acc_q == '0) || (CNT_W'(lag_min_q) >= cnt_q);
						sat_q    <= 1'b0;
						j_q      <= '0;
						end_q    <= cnt_q - CNT_W'(lag_min_q);
						acc_q    <= '0;
					end else begin
						neg_q <= acc_q[ACC_W-1];
						mag_q <= acc_q[ACC_W-1] ? acc_neg : acc_q;
					end
				end
			end
			ST_DIV: begin
				if (step_q == '0) begin
					sat_q  <= (mag_q >= var_q);
					drem_q <= mag_q;
					frac_q <= '0;
				end else if (frac_trial >= {1'b0, var_q}) begin
					drem_q <= ACC_W'(frac_trial - {1'b0, var_q});
					frac_q <= {frac_q[FRAC_STEPS-2:0], 1'b1};
				end else begin
					drem_q <= frac_trial[ACC_W-1:0];
					frac_q <= {frac_q[FRAC_STEPS-2:0], 1'b0};
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					lag_q  <= next_lag;
					zero_q <= next_zero;
					sat_q  <= 1'b0;
					j_q    <= '0;
					end_q  <= cnt_q - CNT_W'(next_lag);
					acc_q  <= '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			sum_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (store_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
						sum_q <= sum_q + SUM_W'($signed(s_tdata));
					end
					if (in_acc && s_tlast) begin
						if (hi_in <= LAG_MAX_W'(lag_min_q)) begin
							// empty lag range: drop the series
							cnt_q <= '0;
							sum_q <= '0;
						end else begin
							state_q <= ST_MEAN;
							step_q  <= '0;
						end
					end
				end
				ST_MEAN: begin
					if (step_q == STEP_W'(NUM_W)) begin
						state_q <= ST_SUM;
						step_q  <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_SUM: begin
					if (sum_done) begin
						if (vphase_q) begin
							if ((acc_q == '0) || (CNT_W'(lag_min_q) >= cnt_q)) begin
								state_q <= ST_EMIT;
							end
						end else begin
							state_q <= ST_DIV;
							step_q  <= '0;
						end
					end
				end
				ST_DIV: begin
					if ((step_q == '0 && mag_q >= var_q) ||
					    step_q == STEP_W'(FRAC_STEPS)) begin
						state_q <= ST_EMIT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (next_lag == hi_q) begin
							state_q <= ST_LOAD;
							cnt_q   <= '0;
							sum_q   <= '0;
						end else if (!next_zero) begin
							state_q <= ST_SUM;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			m_data_q <= {2'b00, corr_val, lag_q[LAG_W-1:0]};
			m_user_q <= undef_q;
			m_last_q <= (next_lag == hi_q);
		end
	end

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_load_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(v_s1 || v_s2 || v_s3))
		else $error("sum pipeline busy while loading samples");
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[21:6] == '0))
		else $error("undefined result with nonzero correlation");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond store depth");
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (j_plus_lag < cnt_q))
		else $error("store read beyond series");
`endif

endmodule

// ===== tb/sv/tb_sample_autocorrelation_unit.sv =====
module tb_sample_autocorrelation_unit;
	import sac_pkg::*;

	localparam int STORE_DEPTH = MAX_SAMPLES_DEF;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [LAG_W-1:0]         lag;
		logic signed [CORR_W-1:0] corr;
		logic                     undef;
		logic                     last;
	} acf_result_t;

	class acf_scoreboard;
		shortint        store[STORE_DEPTH];
		int             count;
		longint         sum;
		int             lag_lo;
		int             lag_hi;
		acf_result_t    pending[$];
		int             errors;
		int             series_done;
		int             results_seen;

		function new();
			count = 0;
			sum = 0;
			lag_lo = 0;
			lag_hi = 64;
			errors = 0;
			series_done = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic idx, int val);
			if (idx == CFG_LAG_MIN)
				lag_lo = val & 'h3f;
			else
				lag_hi = val & 'h7f;
		endfunction

		function longint unsigned lag_products(int lag, longint mean);
			longint unsigned acc;
			longint da, db;
			acc = 0;
			if (lag >= count)
				return 0;
			for (int j = 0; j + lag < count; j++) begin
				da = longint'(store[j]) * 256 - mean;
				db = longint'(store[j + lag]) * 256 - mean;
				acc += longint'(da * db);
			end
			return acc;
		endfunction

		// rounded, saturated Q1.15 of (+/- mag) / den
		function int q15_of(longint unsigned mag, bit neg, longint unsigned den);
			longint unsigned q, r, acc;
			longint v;
			q = mag / den;
			r = mag % den;
			if (q > 2)
				q = 2;
			acc = q;
			for (int k = 0; k < FRAC_STEPS; k++) begin
				if (r >= den - r) begin
					r = r - (den - r);
					acc = acc * 2 + 1;
				end else begin
					r = r + r;
					acc = acc * 2;
				end
			end
			acc = (acc + 1) >> 1;
			v = neg ? -longint'(acc) : longint'(acc);
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			return int'(v);
		endfunction

		function void note_sample(shortint s, bit last);
			longint unsigned mag, m, var0, ls;
			longint num, mean;
			bit neg, undef;
			int hi, c;
			acf_result_t res;
			if (count < STORE_DEPTH) begin
				store[count] = s;
				count++;
				sum += s;
			end
			if (!last)
				return;
			num = sum * 256;
			neg = num < 0;
			mag = neg ? -num : num;
			m = (mag + count / 2) / count;
			mean = neg ? -longint'(m) : longint'(m);
			var0 = lag_products(0, mean);
			undef = var0 == 0;
			hi = lag_hi > MAX_LAGS ? MAX_LAGS : lag_hi;
			for (int lag = lag_lo; lag < hi; lag++) begin
				c = 0;
				if (!undef && lag < count) begin
					ls = lag_products(lag, mean);
					neg = ls[63];
					c = q15_of(neg ? -ls : ls, neg, var0);
				end
				res.lag = LAG_W'(lag);
				res.corr = CORR_W'(c);
				res.undef = undef;
				res.last = (lag + 1 == hi);
				pending.push_back(res);
			end
			count = 0;
			sum = 0;
			series_done++;
		endfunction

		function void check_result(logic [LAG_W-1:0] lag, logic [CORR_W-1:0] corr,
			logic undef, logic last);
			acf_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result lag=%0d corr=%0d undef=%0b last=%0b",
					$time, lag, $signed(corr), undef, last);
				return;
			end
			e = pending.pop_front();
			if (e.lag !== lag || e.corr !== corr || e.undef !== undef || e.last !== last) begin
				errors++;
				$display("%0t: mismatch expected lag=%0d corr=%0d undef=%0b last=%0b",
					$time, e.lag, e.corr, e.undef, e.last);
				$display("%0t:          actual   lag=%0d corr=%0d undef=%0b last=%0b",
					$time, lag, $signed(corr), undef, last);
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_index = 1'b0;
	logic [LAG_MAX_W-1:0]   cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [SAMPLE_BITS-1:0] s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [23:0]            m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	acf_scoreboard sb = new();
	int tx_idle = 0;
	int rx_idle = 0;
	int cycles = 0;
	int items = 0;

	sample_autocorrelation_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= rx_idle);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata[5:0], m_tdata[21:6], m_tuser, m_tlast);
	end

	// valid stays high after a transaction; it drops for random idle gaps and in drain
	task automatic send_sample(shortint s, bit last);
		if ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata <= s;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(s, last);
		items++;
	endtask

	task automatic send_series(int len, int kind);
		shortint base, s;
		base = shortint'($urandom);
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: s = shortint'($urandom);
				1: s = shortint'($signed($urandom_range(0, 63)) - 32);
				2: s = base;
				3: s = i[0] ? 16'sh7fff : 16'sh8000;
				default: s = base + shortint'(i * 37);
			endcase
			send_sample(s, i == len - 1);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		// let the block settle back into loading
		repeat (100) @(posedge clk);
		while (!s_tready)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic set_lags(int lo, int hi);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_LAG_MIN;
		cfg_data <= LAG_MAX_W'(lo);
		@(posedge clk);
		sb.set_reg(CFG_LAG_MIN, lo);
		cfg_index <= CFG_LAG_MAX;
		cfg_data <= LAG_MAX_W'(hi);
		@(posedge clk);
		sb.set_reg(CFG_LAG_MAX, hi);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int len;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default lags, then extremes
		send_series(1, 0);                 // single sample, zero variance
		send_series(4, 2);                 // constant series
		send_series(6, 3);                 // full-scale alternation
		send_series(8, 4);                 // ramp
		set_lags(63, 64);
		send_series(3, 0);                 // lag past the count
		set_lags(10, 5);
		send_series(2, 1);                 // empty lag range
		set_lags(0, 0);
		send_series(1, 1);
		set_lags(5, 100);                  // lag_max clamps
		send_series(2, 0);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = ph == 0 ? 38 : (ph == 1 ? 50 : 0);
			rx_idle = ph == 0 ? 50 : (ph == 1 ? 38 : 0);
			set_lags($urandom_range(0, 8), $urandom_range(8, 64));
			while (items < 30 + 80 * (ph + 1)) begin
				len = ($urandom_range(15) == 0) ? $urandom_range(30, 60)
					: $urandom_range(1, 20);
				send_series(len, $urandom_range(9) < 6 ? 0 : $urandom_range(1, 4));
				if ($urandom_range(5) == 0)
					set_lags($urandom_range(0, 63), $urandom_range(0, 64));
			end
		end

		drain();
		repeat (200) @(posedge clk);
		$display("%0d samples in %0d series, %0d lag results checked",
			items, sb.series_done, sb.results_seen);
		$display("lag ranges incl. empty and clamped, with stalls both ways; mismatches: %0d",
			sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/sac_pkg.sv
rtl/core/sample_autocorrelation_unit.sv
tb/sv/tb_sample_autocorrelation_unit.sv
